// ===== rtl/swmc_pkg.sv =====
package swmc_pkg;

  localparam int S_TDATA_W = 48;
  localparam int M_TDATA_W = 24;

  typedef enum logic [3:0] {
    OP_CMOV  = 4'd0,
    OP_LD    = 4'd1,
    OP_ST    = 4'd2,
    OP_ADD   = 4'd3,
    OP_MUL   = 4'd4,
    OP_DIV   = 4'd5,
    OP_NAND  = 4'd6,
    OP_HALT  = 4'd7,
    OP_MAP   = 4'd8,
    OP_UNMAP = 4'd9,
    OP_OUT   = 4'd10,
    OP_IN    = 4'd11,
    OP_LP    = 4'd12,
    OP_LV    = 4'd13
  } op_e;

  typedef enum logic [1:0] {
    RS_RUN  = 2'd0,
    RS_HALT = 2'd1,
    RS_FAIL = 2'd2
  } run_e;

  typedef enum logic [1:0] {OPND_NONE, OPND_A, OPND_B, OPND_C} opnd_e;

  typedef enum logic [2:0] {RES_NONE, RES_ALU, RES_MEM, RES_ID, RES_QUO} res_e;

  typedef enum logic [1:0] {STA_NONE, STA_FAIL, STA_HALT, STA_ADV} sta_e;

  typedef enum logic [4:0] {
    S_IDLE, S_DECIDE, S_FETCH, S_OPA, S_OPB, S_OPC, S_EXEC, S_LCHK, S_MEMRD,
    S_MAPQ, S_MAPF, S_ZERO, S_DIV, S_DIVF, S_CPLEN, S_CPRD, S_CPWR, S_JUMP,
    S_WB, S_DONE
  } state_e;

  typedef struct packed {
    logic  latch_in;
    logic  load_append;
    logic  fetch_rd;
    logic  latch_word;
    opnd_e opnd;
    res_e  res_src;
    logic  reg_we;
    logic  len_rd;
    logic  len_wr;
    logic  len0_from_len;
    logic  mem_rd_seg;
    logic  mem_wr_seg;
    logic  zero_wr;
    logic  copy_rd;
    logic  copy_wr;
    logic  cnt_clr;
    logic  cnt_inc;
    logic  q_pop;
    logic  q_push;
    logic  id_from_q;
    logic  id_from_fresh;
    logic  div_start;
    logic  div_step;
    logic  emit_out;
    logic  take_in;
    logic  pc_jump;
    sta_e  sta;
    logic  out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic run_ok;
    logic cmd_step;
    logic len0_full;
    logic pc_oob;
    op_e  op;
    logic cond_nz;
    logic id_ok;
    logic idx_ok;
    logic div_zero;
    logic div_last;
    logic map_big;
    logic q_empty;
    logic q_have;
    logic fresh_left;
    logic out_big;
    logic src_zero;
    logic src_bad;
    logic tgt_bad;
    logic cnt_done;
    logic out_busy;
  } dp_stat_t;

endpackage

// ===== rtl/swmc_ram.sv =====
module swmc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/swmc_ctrl.sv =====
module swmc_ctrl import swmc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     s_tvalid_i,
  output logic     s_tready_o,
  input  dp_stat_t stat_i,
  output ctl_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    s_tready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d        = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_d = S_DONE;
        if (stat_i.run_ok) begin
          if (!stat_i.cmd_step) begin
            if (stat_i.len0_full) cmd_o.sta = STA_FAIL;
            else cmd_o.load_append = 1'b1;
          end else if (stat_i.pc_oob) begin
            cmd_o.sta = STA_FAIL;
          end else begin
            cmd_o.fetch_rd = 1'b1;
            state_d        = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        cmd_o.latch_word = 1'b1;
        state_d          = S_OPA;
      end
      S_OPA: begin
        cmd_o.opnd = OPND_A;
        state_d    = S_OPB;
      end
      S_OPB: begin
        cmd_o.opnd = OPND_B;
        state_d    = S_OPC;
      end
      S_OPC: begin
        cmd_o.opnd = OPND_C;
        state_d    = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_DONE;
        case (stat_i.op)
          OP_CMOV: begin
            if (stat_i.cond_nz) begin
              cmd_o.res_src = RES_ALU;
              state_d       = S_WB;
            end else begin
              cmd_o.sta = STA_ADV;
            end
          end
          OP_LD, OP_ST: begin
            if (stat_i.id_ok) begin
              cmd_o.len_rd = 1'b1;
              state_d      = S_LCHK;
            end else begin
              cmd_o.sta = STA_FAIL;
            end
          end
          OP_ADD, OP_MUL, OP_NAND, OP_LV: begin
            cmd_o.res_src = RES_ALU;
            state_d       = S_WB;
          end
          OP_IN: begin
            cmd_o.res_src = RES_ALU;
            cmd_o.take_in = 1'b1;
            state_d       = S_WB;
          end
          OP_DIV: begin
            if (stat_i.div_zero) begin
              cmd_o.sta = STA_FAIL;
            end else begin
              cmd_o.div_start = 1'b1;
              state_d         = S_DIV;
            end
          end
          OP_HALT: cmd_o.sta = STA_HALT;
          OP_MAP: begin
            if (stat_i.map_big) begin
              cmd_o.sta = STA_FAIL;
            end else if (!stat_i.q_empty) begin
              cmd_o.q_pop = 1'b1;
              state_d     = S_MAPQ;
            end else begin
              state_d = S_MAPF;
            end
          end
          OP_UNMAP: begin
            cmd_o.q_push = 1'b1;
            cmd_o.sta    = STA_ADV;
          end
          OP_OUT: begin
            if (stat_i.out_big) begin
              cmd_o.sta = STA_FAIL;
            end else begin
              cmd_o.emit_out = 1'b1;
              cmd_o.sta      = STA_ADV;
            end
          end
          OP_LP: begin
            if (stat_i.src_zero) begin
              state_d = S_JUMP;
            end else if (stat_i.src_bad) begin
              cmd_o.sta = STA_FAIL;
            end else begin
              cmd_o.len_rd = 1'b1;
              state_d      = S_CPLEN;
            end
          end
          default: cmd_o.sta = STA_FAIL;
        endcase
      end
      S_LCHK: begin
        state_d = S_DONE;
        if (!stat_i.idx_ok) begin
          cmd_o.sta = STA_FAIL;
        end else if (stat_i.op == OP_ST) begin
          cmd_o.mem_wr_seg = 1'b1;
          cmd_o.sta        = STA_ADV;
        end else begin
          cmd_o.mem_rd_seg = 1'b1;
          state_d          = S_MEMRD;
        end
      end
      S_MEMRD: begin
        cmd_o.res_src = RES_MEM;
        state_d       = S_WB;
      end
      S_MAPQ: begin
        if (stat_i.q_have) begin
          cmd_o.id_from_q = 1'b1;
          cmd_o.cnt_clr   = 1'b1;
          state_d         = S_ZERO;
        end else begin
          state_d = S_MAPF;
        end
      end
      S_MAPF: begin
        if (stat_i.fresh_left) begin
          cmd_o.id_from_fresh = 1'b1;
          cmd_o.cnt_clr       = 1'b1;
          state_d             = S_ZERO;
        end else begin
          cmd_o.sta = STA_FAIL;
          state_d   = S_DONE;
        end
      end
      S_ZERO: begin
        if (stat_i.cnt_done) begin
          cmd_o.len_wr  = 1'b1;
          cmd_o.res_src = RES_ID;
          state_d       = S_WB;
        end else begin
          cmd_o.zero_wr = 1'b1;
          cmd_o.cnt_inc = 1'b1;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) state_d = S_DIVF;
      end
      S_DIVF: begin
        cmd_o.res_src = RES_QUO;
        state_d       = S_WB;
      end
      S_CPLEN: begin
        cmd_o.cnt_clr = 1'b1;
        state_d       = S_CPRD;
      end
      S_CPRD: begin
        if (stat_i.cnt_done) begin
          cmd_o.len0_from_len = 1'b1;
          state_d             = S_JUMP;
        end else begin
          cmd_o.copy_rd = 1'b1;
          state_d       = S_CPWR;
        end
      end
      S_CPWR: begin
        cmd_o.copy_wr = 1'b1;
        cmd_o.cnt_inc = 1'b1;
        state_d       = S_CPRD;
      end
      S_JUMP: begin
        if (stat_i.tgt_bad) cmd_o.sta = STA_FAIL;
        else cmd_o.pc_jump = 1'b1;
        state_d = S_DONE;
      end
      S_WB: begin
        cmd_o.reg_we = 1'b1;
        cmd_o.sta    = STA_ADV;
        state_d      = S_DONE;
      end
      S_DONE: begin
        if (!stat_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/swmc_dp.sv =====
module swmc_dp import swmc_pkg::*; #(
  parameter int NUM_SEGS  = 64,
  parameter int SEG_WORDS = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ctl_cmd_t             cmd_i,
  output dp_stat_t             stat_o,
  input  logic [S_TDATA_W-1:0] s_tdata_i,
  input  logic                 s_tuser_i,
  input  logic                 m_tready_i,
  output logic                 m_tvalid_o,
  output logic [M_TDATA_W-1:0] m_tdata_o
);

  localparam int ID_W   = $clog2(NUM_SEGS);
  localparam int IDX_W  = $clog2(SEG_WORDS);
  localparam int LEN_W  = $clog2(SEG_WORDS + 1);
  localparam int FID_W  = $clog2(NUM_SEGS + 1);
  localparam int ADDR_W = ID_W + IDX_W;
  localparam int QE_W   = ID_W + 1;

  logic             in_cmd_q;
  logic [31:0]      in_word_q;
  logic [7:0]       in_byte_q;
  logic             in_eof_q;
  logic [31:0]      word_q, ra_q, rb_q, rc_q, res_q;
  logic [31:0]      gpr_q [8];
  logic [IDX_W-1:0] pc_q;
  logic [LEN_W-1:0] len0_q;
  run_e             run_q;
  logic [FID_W-1:0] fresh_q;
  logic [ID_W-1:0]  qhead_q, qtail_q;
  logic [FID_W-1:0] qcount_q;
  logic [ID_W-1:0]  id_q;
  logic [LEN_W-1:0] cnt_q;
  logic [31:0]      quo_q, rem_q;
  logic [4:0]       dcnt_q;
  logic             ov_q, it_q;
  logic [7:0]       ob_q;
  logic             m_valid_q;
  logic [M_TDATA_W-1:0] m_data_q;

  op_e              op;
  logic [2:0]       fa, fb, fc, dst, rd_idx;
  logic [31:0]      rd_val, id_sel, idx_sel, seg_len, alu, pc_ext;
  logic [63:0]      prod;
  logic [32:0]      dtrial, dsub;
  logic             dge;
  logic [LEN_W-1:0] pc_inc, cnt_lim;
  logic             adv_fail, q_notfull;

  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [31:0]       mem_wdata, mem_rdata;
  logic [LEN_W-1:0]  len_rdata;
  logic [QE_W-1:0]   q_wdata, q_rdata;
  logic [ID_W-1:0]   qid;

  assign op     = op_e'(word_q[31:28]);
  assign fa     = word_q[8:6];
  assign fb     = word_q[5:3];
  assign fc     = word_q[2:0];
  assign id_sel  = (op == OP_ST) ? ra_q : rb_q;
  assign idx_sel = (op == OP_ST) ? rb_q : rc_q;
  assign seg_len = (id_sel == 32'd0) ? 32'(len0_q) : 32'(len_rdata);
  assign pc_inc   = LEN_W'(pc_q) + LEN_W'(1);
  assign adv_fail = pc_inc >= len0_q;
  assign q_notfull = qcount_q < FID_W'(NUM_SEGS);
  assign qid       = q_rdata[ID_W-1:0];
  assign cnt_lim   = (op == OP_MAP) ? rc_q[LEN_W-1:0] : len_rdata;
  assign prod      = rb_q * rc_q;
  assign dtrial    = {rem_q, quo_q[31]};
  assign dsub      = dtrial - {1'b0, rc_q};
  assign dge       = dtrial >= {1'b0, rc_q};
  assign pc_ext    = 32'(pc_q);

  always_comb begin
    unique case (cmd_i.opnd)
      OPND_A:  rd_idx = fa;
      OPND_B:  rd_idx = fb;
      default: rd_idx = fc;
    endcase
    rd_val = gpr_q[rd_idx];
  end

  always_comb begin
    case (op)
      OP_MAP:  dst = fb;
      OP_IN:   dst = fc;
      OP_LV:   dst = word_q[27:25];
      default: dst = fa;
    endcase
  end

  always_comb begin
    case (op)
      OP_ADD:  alu = rb_q + rc_q;
      OP_MUL:  alu = prod[31:0];
      OP_NAND: alu = ~(rb_q & rc_q);
      OP_IN:   alu = in_eof_q ? '1 : {24'd0, in_byte_q};
      OP_LV:   alu = {7'd0, word_q[24:0]};
      default: alu = rb_q;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    if (cmd_i.load_append) begin
      mem_we    = 1'b1;
      mem_waddr = {ID_W'(0), len0_q[IDX_W-1:0]};
      mem_wdata = in_word_q;
    end
    if (cmd_i.mem_wr_seg) begin
      mem_we    = 1'b1;
      mem_waddr = {id_sel[ID_W-1:0], idx_sel[IDX_W-1:0]};
      mem_wdata = rc_q;
    end
    if (cmd_i.zero_wr) begin
      mem_we    = 1'b1;
      mem_waddr = {id_q, cnt_q[IDX_W-1:0]};
    end
    if (cmd_i.copy_wr) begin
      mem_we    = 1'b1;
      mem_waddr = {ID_W'(0), cnt_q[IDX_W-1:0]};
      mem_wdata = mem_rdata;
    end
    if (cmd_i.fetch_rd) begin
      mem_re    = 1'b1;
      mem_raddr = {ID_W'(0), pc_q};
    end
    if (cmd_i.mem_rd_seg) begin
      mem_re    = 1'b1;
      mem_raddr = {id_sel[ID_W-1:0], idx_sel[IDX_W-1:0]};
    end
    if (cmd_i.copy_rd) begin
      mem_re    = 1'b1;
      mem_raddr = {rb_q[ID_W-1:0], cnt_q[IDX_W-1:0]};
    end
  end

  assign q_wdata = {|rc_q[31:ID_W], rc_q[ID_W-1:0]};

  swmc_ram #(.WIDTH(32), .DEPTH(1 << ADDR_W)) u_words (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  swmc_ram #(.WIDTH(LEN_W), .DEPTH(NUM_SEGS)) u_lens (
    .clk_i   (clk_i),
    .we_i    (cmd_i.len_wr),
    .waddr_i (id_q),
    .wdata_i (rc_q[LEN_W-1:0]),
    .re_i    (cmd_i.len_rd),
    .raddr_i (id_sel[ID_W-1:0]),
    .rdata_o (len_rdata)
  );

  swmc_ram #(.WIDTH(QE_W), .DEPTH(NUM_SEGS)) u_freeq (
    .clk_i   (clk_i),
    .we_i    (cmd_i.q_push && q_notfull),
    .waddr_i (qtail_q),
    .wdata_i (q_wdata),
    .re_i    (cmd_i.q_pop),
    .raddr_i (qhead_q),
    .rdata_o (q_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) gpr_q[i] <= '0;
      pc_q      <= '0;
      len0_q    <= '0;
      run_q     <= RS_RUN;
      fresh_q   <= FID_W'(1);
      qhead_q   <= '0;
      qtail_q   <= '0;
      qcount_q  <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (cmd_i.reg_we) gpr_q[dst] <= res_q;
      if (cmd_i.load_append) len0_q <= len0_q + LEN_W'(1);
      if (cmd_i.len0_from_len) len0_q <= len_rdata;
      if (cmd_i.pc_jump) pc_q <= rc_q[IDX_W-1:0];
      unique case (cmd_i.sta)
        STA_FAIL: run_q <= RS_FAIL;
        STA_HALT: run_q <= RS_HALT;
        STA_ADV: begin
          if (adv_fail) run_q <= RS_FAIL;
          else pc_q <= pc_inc[IDX_W-1:0];
        end
        default: ;
      endcase
      if (cmd_i.id_from_fresh) fresh_q <= fresh_q + FID_W'(1);
      if (cmd_i.q_pop) begin
        qhead_q  <= (qhead_q == ID_W'(NUM_SEGS - 1)) ? '0 : qhead_q + ID_W'(1);
        qcount_q <= qcount_q - FID_W'(1);
      end
      if (cmd_i.q_push && q_notfull) begin
        qtail_q  <= (qtail_q == ID_W'(NUM_SEGS - 1)) ? '0 : qtail_q + ID_W'(1);
        qcount_q <= qcount_q + FID_W'(1);
      end
      if (cmd_i.out_load) m_valid_q <= 1'b1;
      else if (m_tready_i) m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      in_cmd_q  <= s_tuser_i;
      in_word_q <= s_tdata_i[31:0];
      in_byte_q <= s_tdata_i[39:32];
      in_eof_q  <= s_tdata_i[40];
      ov_q      <= 1'b0;
      ob_q      <= '0;
      it_q      <= 1'b0;
    end
    if (cmd_i.latch_word) word_q <= mem_rdata;
    unique case (cmd_i.opnd)
      OPND_A:  ra_q <= rd_val;
      OPND_B:  rb_q <= rd_val;
      OPND_C:  rc_q <= rd_val;
      default: ;
    endcase
    unique case (cmd_i.res_src)
      RES_ALU: res_q <= alu;
      RES_MEM: res_q <= mem_rdata;
      RES_ID:  res_q <= 32'(id_q);
      RES_QUO: res_q <= quo_q;
      default: ;
    endcase
    if (cmd_i.id_from_q) id_q <= qid;
    if (cmd_i.id_from_fresh) id_q <= fresh_q[ID_W-1:0];
    if (cmd_i.cnt_clr) cnt_q <= '0;
    else if (cmd_i.cnt_inc) cnt_q <= cnt_q + LEN_W'(1);
    if (cmd_i.div_start) begin
      quo_q  <= rb_q;
      rem_q  <= '0;
      dcnt_q <= '0;
    end else if (cmd_i.div_step) begin
      quo_q  <= {quo_q[30:0], dge};
      rem_q  <= dge ? dsub[31:0] : dtrial[31:0];
      dcnt_q <= dcnt_q + 5'd1;
    end
    if (cmd_i.emit_out) begin
      ov_q <= 1'b1;
      ob_q <= rc_q[7:0];
    end
    if (cmd_i.take_in) it_q <= 1'b1;
    if (cmd_i.out_load) m_data_q <= {2'b00, pc_ext[9:0], it_q, ob_q, ov_q, run_q};
  end

  always_comb begin
    stat_o.run_ok     = run_q == RS_RUN;
    stat_o.cmd_step   = in_cmd_q;
    stat_o.len0_full  = len0_q >= LEN_W'(SEG_WORDS);
    stat_o.pc_oob     = LEN_W'(pc_q) >= len0_q;
    stat_o.op         = op;
    stat_o.cond_nz    = rc_q != 32'd0;
    stat_o.id_ok      = id_sel < 32'(fresh_q);
    stat_o.idx_ok     = idx_sel < seg_len;
    stat_o.div_zero   = rc_q == 32'd0;
    stat_o.div_last   = dcnt_q == 5'd31;
    stat_o.map_big    = rc_q > 32'(SEG_WORDS);
    stat_o.q_empty    = qcount_q == '0;
    stat_o.q_have     = !q_rdata[ID_W] && (qid != '0) && (FID_W'(qid) < fresh_q);
    stat_o.fresh_left = fresh_q < FID_W'(NUM_SEGS);
    stat_o.out_big    = rc_q >= 32'd256;
    stat_o.src_zero   = rb_q == 32'd0;
    stat_o.src_bad    = rb_q >= 32'(fresh_q);
    stat_o.tgt_bad    = rc_q >= 32'(len0_q);
    stat_o.cnt_done   = cnt_q == cnt_lim;
    stat_o.out_busy   = m_valid_q && !m_tready_i;
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = m_data_q;

endmodule

// ===== rtl/segmented_word_machine_core.sv =====
// channel   dir  beat contents
// s_axis    in   tuser: command; tdata: load_word, in_byte, in_eof
// m_axis    out  tdata: status, out_valid, out_byte, in_taken, pc_now
//
// One input beat at a time; its result beat leaves through an output register.
// A plain instruction runs fetch, three register reads, execute and write back;
// divide adds a bit-serial shift-subtract loop, map zeroes the new segment word by
// word, and load program copies the source segment into segment 0 word by word.
// The steps are set by the state sequencer and the registered read of the word
// memory. Reset clears the machine with no sweep.
// A stalled result beat holds the sequencer at its last step.
module segmented_word_machine_core import swmc_pkg::*; #(
  parameter int NUM_SEGS  = 64,
  parameter int SEG_WORDS = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,  // load_word, in_byte, in_eof, pad
  input  logic                 s_axis_tuser,  // command
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata   // status, out_valid, out_byte,
                                              // in_taken, pc_now, pad
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  swmc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  swmc_dp #(.NUM_SEGS(NUM_SEGS), .SEG_WORDS(SEG_WORDS)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .s_tdata_i  (s_axis_tdata),
    .s_tuser_i  (s_axis_tuser),
    .m_tready_i (m_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tdata_o  (m_axis_tdata)
  );

endmodule

// ===== rtl/swmc_checker.sv =====
module swmc_checker import swmc_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic [S_TDATA_W-1:0] s_axis_tdata,
  input logic                 s_axis_tuser,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata
);

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while an item is in flight");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result beat changed");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3 && m_axis_tdata[23:22] == 2'd0)
    else $error("bad status or pad in result beat");

  a_reset: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("result beat during reset");

endmodule

bind segmented_word_machine_core swmc_checker u_swmc_checker (.*);
